>>> rtl/core/page_replacement_engine_defines.svh
// Assertion macros shared by the page replacement engine RTL.
`ifndef PAGE_REPLACEMENT_ENGINE_DEFINES_SVH
`define PAGE_REPLACEMENT_ENGINE_DEFINES_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define PRE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define PRE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/pre_pkg.sv
// Package with the constants and types of the page replacement engine.
`timescale 1ns / 1ps
package pre_pkg;

  localparam int MAX_FRAMES  = 8;
  localparam int PAGE_BITS   = 16;
  localparam int FRAME_IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int FRAME_CNT_W = $clog2(MAX_FRAMES + 1);

  // Fixed field widths of the ports.
  localparam int SLOT_W     = 3;
  localparam int COUNT_W    = 16;
  localparam int POLICY_W   = 2;
  localparam int CFG_FRM_W  = 4;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Replacement policy codes; the unused code behaves as FIFO.
  localparam logic [POLICY_W-1:0] POLICY_FIFO = 2'd0;
  localparam logic [POLICY_W-1:0] POLICY_LRU  = 2'd1;
  localparam logic [POLICY_W-1:0] POLICY_SC   = 2'd2;

  // Register indexes, taken from address bit 2.
  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_FRAMES = 1'b1;

  localparam logic [POLICY_W-1:0]  POLICY_RESET = POLICY_FIFO;
  localparam logic [CFG_FRM_W-1:0] FRAMES_RESET = 4'd4;

  // One reference as seen by the frame and recency logic.
  typedef struct packed {
    logic                   step;
    logic [PAGE_BITS-1:0]   page;
    logic [MAX_FRAMES-1:0]  active;
    logic [FRAME_IDX_W-1:0] last_idx;
    logic [POLICY_W-1:0]    mode;
  } pre_req_t;

  // Outcome of one reference.
  typedef struct packed {
    logic                   fault;
    logic [FRAME_IDX_W-1:0] slot;
    logic                   ev_valid;
    logic [PAGE_BITS-1:0]   ev_page;
  } pre_res_t;

endpackage

>>> rtl/core/pre_recency.sv
// Recency list of referenced pages, most recent entry first.
`timescale 1ns / 1ps
`include "page_replacement_engine_defines.svh"
module pre_recency
  import pre_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pre_req_t             req_i,
  output logic [PAGE_BITS-1:0] rec_page_o [MAX_FRAMES],
  output logic [MAX_FRAMES-1:0] rec_valid_o
);

  logic [PAGE_BITS-1:0]   rec_page_q [MAX_FRAMES];
  logic [PAGE_BITS-1:0]   rec_page_d [MAX_FRAMES];
  logic [MAX_FRAMES-1:0]  rec_valid_q, rec_valid_d;
  logic                   found;
  logic [FRAME_IDX_W-1:0] first_idx, depth;

  always_comb begin
    found     = 1'b0;
    first_idx = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (req_i.active[i] && rec_valid_q[i] && (rec_page_q[i] == req_i.page)) begin
        found     = 1'b1;
        first_idx = FRAME_IDX_W'(i);
      end
    end
    // A page not in the list pushes everything down and drops the last entry.
    depth = found ? first_idx : req_i.last_idx;

    rec_page_d  = rec_page_q;
    rec_valid_d = rec_valid_q;
    if (req_i.step) begin
      for (int i = 1; i < MAX_FRAMES; i++) begin
        if (FRAME_IDX_W'(i) <= depth) begin
          rec_page_d[i]  = rec_page_q[i-1];
          rec_valid_d[i] = rec_valid_q[i-1];
        end
      end
      rec_page_d[0]  = req_i.page;
      rec_valid_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_valid_q <= '0;
    end else begin
      rec_valid_q <= rec_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_page_q <= rec_page_d;
  end

  assign rec_page_o  = rec_page_q;
  assign rec_valid_o = rec_valid_q;

  `PRE_ASSERT_NEXT(a_mru_head, clk_i, rst_ni, req_i.step, rec_valid_q[0] && (rec_page_q[0] == $past(req_i.page)), "referenced page is not at the head of the recency list")

endmodule

>>> rtl/core/pre_frames.sv
// Frame table with hit detection, victim selection and replacement.
`timescale 1ns / 1ps
`include "page_replacement_engine_defines.svh"
module pre_frames
  import pre_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pre_req_t              req_i,
  input  logic [PAGE_BITS-1:0]  rec_page_i [MAX_FRAMES],
  input  logic [MAX_FRAMES-1:0] rec_valid_i,
  output pre_res_t              res_o
);

  logic [PAGE_BITS-1:0]   fp_q [MAX_FRAMES];
  logic [PAGE_BITS-1:0]   fp_d [MAX_FRAMES];
  logic [MAX_FRAMES-1:0]  fv_q, fv_d, ref_q, ref_d;

  logic                   is_lru, is_sc, is_fifo;
  logic                   hit, has_empty, sc_found;
  logic [FRAME_IDX_W-1:0] hit_idx, empty_idx, lru_idx, sc_idx, vic_idx;
  logic [MAX_FRAMES-1:0]  row_any, sc_clr;
  logic [FRAME_IDX_W-1:0] row_col [MAX_FRAMES];
  logic                   fault, ev_valid;

  assign is_lru  = (req_i.mode == POLICY_LRU);
  assign is_sc   = (req_i.mode == POLICY_SC);
  assign is_fifo = !(is_lru || is_sc);

  always_comb begin
    hit       = 1'b0;
    hit_idx   = '0;
    has_empty = 1'b0;
    empty_idx = '0;
    sc_found  = 1'b0;
    sc_idx    = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (req_i.active[i] && fv_q[i] && (fp_q[i] == req_i.page)) begin
        hit     = 1'b1;
        hit_idx = FRAME_IDX_W'(i);
      end
      if (req_i.active[i] && !fv_q[i]) begin
        has_empty = 1'b1;
        empty_idx = FRAME_IDX_W'(i);
      end
      if (req_i.active[i] && !ref_q[i]) begin
        sc_found = 1'b1;
        sc_idx   = FRAME_IDX_W'(i);
      end
    end

    // Second chance clears every bit it passes over on the way to the victim.
    for (int i = 0; i < MAX_FRAMES; i++) begin
      sc_clr[i] = req_i.active[i] && (!sc_found || (FRAME_IDX_W'(i) < sc_idx));
    end

    // For each recency entry, the lowest frame that holds its page.
    for (int r = 0; r < MAX_FRAMES; r++) begin
      row_any[r] = 1'b0;
      row_col[r] = '0;
      for (int j = MAX_FRAMES - 1; j >= 0; j--) begin
        if (req_i.active[r] && rec_valid_i[r] && req_i.active[j] && fv_q[j] &&
            (rec_page_i[r] == fp_q[j])) begin
          row_any[r] = 1'b1;
          row_col[r] = FRAME_IDX_W'(j);
        end
      end
    end
    // The deepest resident entry names the victim.
    lru_idx = req_i.last_idx;
    for (int r = 0; r < MAX_FRAMES; r++) begin
      if (row_any[r]) begin
        lru_idx = row_col[r];
      end
    end

    priority if (is_fifo) begin
      vic_idx = req_i.last_idx;
    end else if (has_empty) begin
      vic_idx = empty_idx;
    end else if (is_lru) begin
      vic_idx = lru_idx;
    end else begin
      vic_idx = sc_idx;
    end

    fault    = req_i.step && !hit;
    ev_valid = fault && (is_fifo ? fv_q[vic_idx] : !has_empty);

    fp_d  = fp_q;
    fv_d  = fv_q;
    ref_d = ref_q;
    if (req_i.step) begin
      if (hit) begin
        if (is_sc) begin
          ref_d[hit_idx] = 1'b1;
        end
      end else if (is_fifo) begin
        for (int i = 1; i < MAX_FRAMES; i++) begin
          if (req_i.active[i]) begin
            fp_d[i]  = fp_q[i-1];
            fv_d[i]  = fv_q[i-1];
            ref_d[i] = ref_q[i-1];
          end
        end
        fp_d[0]  = req_i.page;
        fv_d[0]  = 1'b1;
        ref_d[0] = 1'b0;
      end else begin
        if (is_sc && !has_empty) begin
          ref_d = ref_q & ~sc_clr;
        end
        fp_d[vic_idx]  = req_i.page;
        fv_d[vic_idx]  = 1'b1;
        ref_d[vic_idx] = 1'b0;
      end
    end

    res_o.fault    = fault;
    res_o.slot     = hit ? hit_idx : (is_fifo ? '0 : vic_idx);
    res_o.ev_valid = ev_valid;
    res_o.ev_page  = ev_valid ? fp_q[vic_idx] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q  <= '0;
      ref_q <= '0;
    end else begin
      fv_q  <= fv_d;
      ref_q <= ref_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fp_q <= fp_d;
  end

  `PRE_ASSERT_NEXT(a_loaded_valid, clk_i, rst_ni, req_i.step && res_o.fault, fv_q[$past(res_o.slot)], "loaded frame is not valid after a fault")
  `PRE_ASSERT_SAME(a_hit_no_evict, clk_i, rst_ni, !res_o.fault, !res_o.ev_valid && (res_o.ev_page == '0), "eviction reported without a fault")

endmodule

>>> rtl/core/page_replacement_engine.sv
// Top level of the page replacement engine: register port, input and result registers.
//
// The engine takes one page reference per word and keeps up to eight page frames in
// flip-flops. Every reference is compared against all active frames at once; a hit
// reports the frame, a miss counts a fault, loads the page and reports any evicted page.
// The policy register selects FIFO (frames shift down, the new page enters frame 0),
// least recently used (an empty frame first, else the frame of the deepest resident
// recency entry) or second chance (an empty frame first, else a scan from frame 0 that
// clears set reference bits and takes the first clear one, frame 0 if all were set).
// The unused policy code acts as FIFO. A frame count of 0 acts as 1 and counts above 8
// act as 8; frames above the count keep their contents untouched. The fault total
// saturates at 65535. A reference is captured in an input register and resolved by the
// compare and selection logic into the result register, so the engine takes one word
// per cycle while the result output is not stalled. The input register drains into the
// result register whenever that register is empty or being taken, so a waiting result
// does not block the next word. The user must write configuration through the APB port
// only while the engine is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`include "page_replacement_engine_defines.svh"
module page_replacement_engine
  import pre_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // Reference input.
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PAGE_BITS-1:0]  page_number_i,
  // Result output.
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  page_fault_o,
  output logic [SLOT_W-1:0]     frame_slot_o,
  output logic                  evicted_valid_o,
  output logic [PAGE_BITS-1:0]  evicted_page_o,
  output logic [COUNT_W-1:0]    fault_total_o
);

  logic [POLICY_W-1:0]    policy_q;
  logic [CFG_FRM_W-1:0]   frames_q;
  logic                   cfg_wr;

  logic                   s0_valid_q, s0_valid_d;
  logic [PAGE_BITS-1:0]   s0_page_q;
  logic                   in_take, advance;

  logic [FRAME_CNT_W-1:0] n_active;
  pre_req_t               req;
  pre_res_t               res;
  logic [PAGE_BITS-1:0]   rec_page [MAX_FRAMES];
  logic [MAX_FRAMES-1:0]  rec_valid;

  logic [COUNT_W-1:0]     fault_cnt_q, fault_cnt_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_fault_q;
  logic [SLOT_W-1:0]      out_slot_q;
  logic                   out_ev_valid_q;
  logic [PAGE_BITS-1:0]   out_ev_page_q;
  logic [COUNT_W-1:0]     out_total_q;

  // Register port: always ready, registers decoded from address bit 2.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_FRAMES) ? APB_DATA_W'(frames_q) : APB_DATA_W'(policy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POLICY_RESET;
      frames_q <= FRAMES_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_POLICY) begin
        policy_q <= pwdata[POLICY_W-1:0];
      end else begin
        frames_q <= pwdata[CFG_FRM_W-1:0];
      end
    end
  end

  // Active frame count clamped to the range one to the frame capacity.
  always_comb begin
    priority if (frames_q == '0) begin
      n_active = FRAME_CNT_W'(1);
    end else if (32'(frames_q) > 32'(MAX_FRAMES)) begin
      n_active = FRAME_CNT_W'(MAX_FRAMES);
    end else begin
      n_active = FRAME_CNT_W'(frames_q);
    end
  end

  // The input register moves on whenever the result register can take a word.
  assign advance    = s0_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s0_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    priority if (in_take) begin
      s0_valid_d = 1'b1;
    end else if (advance) begin
      s0_valid_d = 1'b0;
    end else begin
      s0_valid_d = s0_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= s0_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s0_page_q <= page_number_i;
    end
  end

  always_comb begin
    req.step     = advance;
    req.page     = s0_page_q;
    req.mode     = policy_q;
    req.last_idx = FRAME_IDX_W'(n_active - FRAME_CNT_W'(1));
    for (int i = 0; i < MAX_FRAMES; i++) begin
      req.active[i] = (FRAME_CNT_W'(i) < n_active);
    end
  end

  pre_recency u_recency (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .rec_page_o  (rec_page),
    .rec_valid_o (rec_valid)
  );

  pre_frames u_frames (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .rec_page_i  (rec_page),
    .rec_valid_i (rec_valid),
    .res_o       (res)
  );

  // Saturating fault counter; the result carries the count after this reference.
  assign fault_cnt_d = (res.fault && (fault_cnt_q != '1)) ? fault_cnt_q + COUNT_W'(1)
                                                          : fault_cnt_q;

  always_comb begin
    priority if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fault_cnt_q <= fault_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_fault_q    <= res.fault;
      out_slot_q     <= SLOT_W'(res.slot);
      out_ev_valid_q <= res.ev_valid;
      out_ev_page_q  <= res.ev_page;
      out_total_q    <= fault_cnt_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign page_fault_o    = out_fault_q;
  assign frame_slot_o    = out_slot_q;
  assign evicted_valid_o = out_ev_valid_q;
  assign evicted_page_o  = out_ev_page_q;
  assign fault_total_o   = out_total_q;

  `PRE_ASSERT_NEXT(a_cnt_mono, clk_i, rst_ni, 1'b1, fault_cnt_q >= $past(fault_cnt_q), "fault counter went backward")
  `PRE_ASSERT_NEXT(a_adv_out, clk_i, rst_ni, advance, out_valid_o, "resolved reference did not reach the result register")

endmodule
